// ----- rtl/core/id_pool_free_list_allocator_defines.svh -----
// ---------------------------------------------------------------------------
// ID pool allocator assertion macros
// Shorthand for clocked assertions on the clock and reset of the using module.
// ---------------------------------------------------------------------------
`ifndef ID_POOL_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define ID_POOL_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define IPFL_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define IPFL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/ipfl_pkg.sv -----
// ---------------------------------------------------------------------------
// ID pool allocator package
// Field widths, defaults, operation and status codes, sequencer states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipfl_pkg;

   localparam int POOL_SIZE_DEF    = 32;
   localparam int MAX_TEXT_LEN_DEF = 100;

   localparam int MODE_W   = 2;
   localparam int ENTRY_W  = 5;
   localparam int TEXT_W   = 8;
   localparam int STATUS_W = 3;
   localparam int RID_W    = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_LIST    = 2'd2,
      MODE_LOOKUP  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_LONG      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC_RD,
      S_REL_HEAD,
      S_REL_WALK,
      S_REL_UNLINK,
      S_REL_PUSH,
      S_LOOK,
      S_LIST,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/ipfl_link_table.sv -----
// ---------------------------------------------------------------------------
// ID pool link table
// Next-pointer memory, one write and one registered read per cycle. An entry
// never written reads as its reset link, the following ID.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipfl_link_table #(
   parameter int POOL_SIZE = ipfl_pkg::POOL_SIZE_DEF,
   localparam int ID_W   = $clog2(POOL_SIZE),
   localparam int LINK_W = $clog2(POOL_SIZE + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [ID_W-1:0]   rd_addr,
   output logic      [LINK_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [ID_W-1:0]   wr_addr,
   input  wire logic [LINK_W-1:0] wr_data
);

   logic [LINK_W-1:0]    mem [POOL_SIZE];
   logic [POOL_SIZE-1:0] valid_ff;
   logic [LINK_W-1:0]    rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // hold the last read until the next one is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr]
                                         : LINK_W'(rd_addr) + LINK_W'(1);
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/id_pool_free_list_allocator.sv -----
// ---------------------------------------------------------------------------
// ID pool free list allocator
// Hands out and takes back entry IDs from a fixed pool kept as a free list
// and an ordered active list in one next-pointer table.
// ---------------------------------------------------------------------------
// One word at a time is worked on; req_stall is high from acceptance until
// its last result is in the output register. Release and look up walk the
// active list one link per cycle, and list gives one word per active ID, one
// per cycle while the output is not stalled. The walk rate is set by the
// single read port of the link table. The output register lets the next
// word in while a result waits.
`timescale 1ns / 1ps
`default_nettype none

`include "id_pool_free_list_allocator_defines.svh"

module id_pool_free_list_allocator #(
   parameter int POOL_SIZE    = ipfl_pkg::POOL_SIZE_DEF,
   parameter int MAX_TEXT_LEN = ipfl_pkg::MAX_TEXT_LEN_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [ipfl_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [ipfl_pkg::ENTRY_W-1:0]  req_entry_id,
   input  wire logic [ipfl_pkg::TEXT_W-1:0]   req_text_length,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [ipfl_pkg::STATUS_W-1:0] rsp_status,
   output logic      [ipfl_pkg::RID_W-1:0]    rsp_result_id,
   output logic                               rsp_last
);

   localparam int ID_W   = $clog2(POOL_SIZE);
   localparam int LINK_W = $clog2(POOL_SIZE + 1);
   localparam int CMP_W  = (LINK_W > ipfl_pkg::ENTRY_W) ? LINK_W : ipfl_pkg::ENTRY_W;
   localparam logic [LINK_W-1:0] NIL    = LINK_W'(POOL_SIZE);
   localparam logic [ID_W-1:0]   LAST_N = ID_W'(POOL_SIZE - 1);
   localparam logic [ipfl_pkg::TEXT_W-1:0] TEXT_LIMIT = ipfl_pkg::TEXT_W'(MAX_TEXT_LEN);

   ipfl_pkg::state_type  state_ff, state_in;
   logic [ipfl_pkg::ENTRY_W-1:0] id_ff, id_in;
   logic [LINK_W-1:0]    p_ff, p_in;
   logic [LINK_W-1:0]    q_ff, q_in;
   logic [ID_W-1:0]      n_ff, n_in;
   logic [LINK_W-1:0]    free_head_ff, free_head_in;
   logic [LINK_W-1:0]    active_head_ff, active_head_in;
   ipfl_pkg::status_type res_status_ff, res_status_in;
   logic [ipfl_pkg::RID_W-1:0] res_id_ff, res_id_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ipfl_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [ipfl_pkg::RID_W-1:0] rsp_id_ff, rsp_id_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic              rd_en;
   logic [ID_W-1:0]   rd_addr;
   logic [LINK_W-1:0] rd_data;
   logic              wr_en;
   logic [ID_W-1:0]   wr_addr;
   logic [LINK_W-1:0] wr_data;

   logic [CMP_W-1:0]  req_id_ext;
   logic [CMP_W-1:0]  id_ext;
   logic              slot_free;
   logic              list_fin;

   ipfl_link_table #(
      .POOL_SIZE (POOL_SIZE)
   ) u_link_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_id_ext = CMP_W'(req_entry_id);
   assign id_ext     = CMP_W'(id_ff);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign list_fin   = (rd_data == NIL) || (n_ff >= LAST_N);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ipfl_pkg::S_IDLE;
         free_head_ff   <= '0;
         active_head_ff <= NIL;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         free_head_ff   <= free_head_in;
         active_head_ff <= active_head_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      n_ff          <= n_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in       = state_ff;
      id_in          = id_ff;
      p_in           = p_ff;
      q_in           = q_ff;
      n_in           = n_ff;
      free_head_in   = free_head_ff;
      active_head_in = active_head_ff;
      res_status_in  = res_status_ff;
      res_id_in      = res_id_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_last_in    = rsp_last_ff;
      rd_en          = 1'b0;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = '0;
      req_stall      = (state_ff != ipfl_pkg::S_IDLE);

      case (state_ff)
         ipfl_pkg::S_IDLE: begin
            if (req_valid) begin
               id_in     = req_entry_id;
               n_in      = '0;
               p_in      = active_head_ff;
               res_id_in = '0;
               state_in  = ipfl_pkg::S_DONE;
               case (ipfl_pkg::mode_type'(req_mode))
                  ipfl_pkg::MODE_ALLOC: begin
                     if (free_head_ff == NIL) begin
                        res_status_in = ipfl_pkg::ST_FULL;
                     end else if (req_text_length >= TEXT_LIMIT) begin
                        res_status_in = ipfl_pkg::ST_LONG;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = free_head_ff[ID_W-1:0];
                        state_in = ipfl_pkg::S_ALLOC_RD;
                     end
                  end
                  ipfl_pkg::MODE_RELEASE: begin
                     if (req_id_ext >= CMP_W'(POOL_SIZE) || active_head_ff == NIL) begin
                        res_status_in = ipfl_pkg::ST_NOT_FOUND;
                     end else if (CMP_W'(active_head_ff) == req_id_ext) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_id_ext[ID_W-1:0];
                        state_in = ipfl_pkg::S_REL_HEAD;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = active_head_ff[ID_W-1:0];
                        state_in = ipfl_pkg::S_REL_WALK;
                     end
                  end
                  ipfl_pkg::MODE_LIST: begin
                     if (active_head_ff == NIL) begin
                        res_status_in = ipfl_pkg::ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = active_head_ff[ID_W-1:0];
                        state_in = ipfl_pkg::S_LIST;
                     end
                  end
                  default: begin
                     if (active_head_ff == NIL) begin
                        res_status_in = ipfl_pkg::ST_NOT_FOUND;
                     end else if (CMP_W'(active_head_ff) == req_id_ext) begin
                        res_status_in = ipfl_pkg::ST_OK;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = active_head_ff[ID_W-1:0];
                        state_in = ipfl_pkg::S_LOOK;
                     end
                  end
               endcase
            end
         end

         ipfl_pkg::S_ALLOC_RD: begin
            // pop the free head, push it onto the active list
            free_head_in   = rd_data;
            active_head_in = free_head_ff;
            wr_en          = 1'b1;
            wr_addr        = free_head_ff[ID_W-1:0];
            wr_data        = active_head_ff;
            res_status_in  = ipfl_pkg::ST_OK;
            res_id_in      = ipfl_pkg::RID_W'(free_head_ff);
            state_in       = ipfl_pkg::S_DONE;
         end

         ipfl_pkg::S_REL_HEAD: begin
            active_head_in = rd_data;
            free_head_in   = LINK_W'(id_ext);
            wr_en          = 1'b1;
            wr_addr        = id_ext[ID_W-1:0];
            wr_data        = free_head_ff;
            res_status_in  = ipfl_pkg::ST_OK;
            state_in       = ipfl_pkg::S_DONE;
         end

         ipfl_pkg::S_REL_WALK: begin
            // rd_data is the successor of p
            if (rd_data == NIL) begin
               res_status_in = ipfl_pkg::ST_NOT_FOUND;
               state_in      = ipfl_pkg::S_DONE;
            end else if (CMP_W'(rd_data) == id_ext) begin
               q_in     = rd_data;
               rd_en    = 1'b1;
               rd_addr  = rd_data[ID_W-1:0];
               state_in = ipfl_pkg::S_REL_UNLINK;
            end else if (n_ff >= LAST_N) begin
               res_status_in = ipfl_pkg::ST_NOT_FOUND;
               state_in      = ipfl_pkg::S_DONE;
            end else begin
               p_in    = rd_data;
               n_in    = n_ff + ID_W'(1);
               rd_en   = 1'b1;
               rd_addr = rd_data[ID_W-1:0];
            end
         end

         ipfl_pkg::S_REL_UNLINK: begin
            // bypass q in the active list
            wr_en    = 1'b1;
            wr_addr  = p_ff[ID_W-1:0];
            wr_data  = rd_data;
            state_in = ipfl_pkg::S_REL_PUSH;
         end

         ipfl_pkg::S_REL_PUSH: begin
            wr_en         = 1'b1;
            wr_addr       = q_ff[ID_W-1:0];
            wr_data       = free_head_ff;
            free_head_in  = q_ff;
            res_status_in = ipfl_pkg::ST_OK;
            state_in      = ipfl_pkg::S_DONE;
         end

         ipfl_pkg::S_LOOK: begin
            if (n_ff >= LAST_N || rd_data == NIL) begin
               res_status_in = ipfl_pkg::ST_NOT_FOUND;
               state_in      = ipfl_pkg::S_DONE;
            end else if (CMP_W'(rd_data) == id_ext) begin
               res_status_in = ipfl_pkg::ST_OK;
               state_in      = ipfl_pkg::S_DONE;
            end else begin
               n_in    = n_ff + ID_W'(1);
               rd_en   = 1'b1;
               rd_addr = rd_data[ID_W-1:0];
            end
         end

         ipfl_pkg::S_LIST: begin
            // emit p; rd_data holds its successor until the word goes out
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ipfl_pkg::ST_OK;
               rsp_id_in     = ipfl_pkg::RID_W'(p_ff);
               rsp_last_in   = list_fin;
               if (list_fin) begin
                  state_in = ipfl_pkg::S_IDLE;
               end else begin
                  p_in    = rd_data;
                  n_in    = n_ff + ID_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = rd_data[ID_W-1:0];
               end
            end
         end

         ipfl_pkg::S_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_last_in   = 1'b1;
               state_in      = ipfl_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ipfl_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_last      = rsp_last_ff;

   `IPFL_ASSERT(a_heads_disjoint,
      (free_head_ff == NIL && active_head_ff == NIL) || (free_head_ff != active_head_ff),
      "free and active heads name the same ID")
   `IPFL_ASSERT_IMP(a_fail_zero_id,
      rsp_valid_ff && (rsp_status_ff != ipfl_pkg::ST_OK), rsp_id_ff == '0,
      "failed result carries a nonzero ID")
   `IPFL_ASSERT_IMP(a_more_only_ok,
      rsp_valid_ff && !rsp_last_ff, rsp_status_ff == ipfl_pkg::ST_OK,
      "non-final result with a failure status")
   `IPFL_ASSERT_IMP(a_list_nonempty,
      state_ff == ipfl_pkg::S_LIST, active_head_ff != NIL && p_ff != NIL,
      "list walk on an empty active list")

endmodule

`default_nettype wire
